/* rtl/core/ax25_frame_afsk_tone_encoder_macros.svh */
// assertion helpers shared by the encoder modules
`ifndef AX25_FRAME_AFSK_TONE_ENCODER_MACROS_SVH
`define AX25_FRAME_AFSK_TONE_ENCODER_MACROS_SVH

// property checked on every rising clk edge outside reset
`define AX25_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// overlapping implication shorthand
`define AX25_ASSERT_IMP(label, ante, cons, msg) \
	`AX25_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication shorthand
`define AX25_ASSERT_NXT(label, ante, cons, msg) \
	`AX25_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* rtl/core/ax25afsk_pkg.sv */
package ax25afsk_pkg;

	localparam int unsigned CNT_W = 6;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] CTRL_BYTE = 8'h03;
	localparam logic [7:0] PID_BYTE  = 8'hF0;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [CNT_W-1:0] COUNT_MAX = 6'd32;

	localparam logic [CNT_W-1:0] PREAMBLE_RESET = 6'd25;
	localparam logic [CNT_W-1:0] TAIL_RESET     = 6'd5;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_PAYLOAD = 2'd1,
		CMD_END     = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CALLSIGN = 2'd0,
		REG_SSID     = 2'd1,
		REG_PREAMBLE = 2'd2,
		REG_TAIL     = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PRE,
		PH_ADDR1,
		PH_ADDR2,
		PH_CTRL,
		PH_PID,
		PH_DATA,
		PH_CRCLO,
		PH_CRCHI,
		PH_TAIL
	} phase_t;

	// one frame byte leaving the sequencer
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       last;
		logic       fold;
		logic       restart;
	} emit_t;

	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
		return (v > COUNT_MAX) ? COUNT_MAX : v;
	endfunction

endpackage

/* rtl/core/ax25afsk_crc.sv */
module ax25afsk_crc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ax25afsk_pkg::emit_t  emit,
	output logic [15:0]          crc
);
	import ax25afsk_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  x;
	logic [15:0] crc_next;

	always_comb begin
		x = crc_q[15:8] ^ emit.data;
		x = x ^ {4'd0, x[7:4]};
		crc_next = {crc_q[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (emit.restart) begin
			crc_q <= CRC_INIT;
		end else if (emit.emit && emit.fold) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule

/* rtl/core/ax25afsk_nrzi.sv */
`include "ax25_frame_afsk_tone_encoder_macros.svh"

module ax25afsk_nrzi (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ax25afsk_pkg::emit_t  emit,
	output logic                 adv,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // sent_byte [7:0], tones [15:8]
	output logic                 m_tlast
);
	import ax25afsk_pkg::*;

	logic       tone_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [7:0] tones_q;
	logic       last_q;
	logic [7:0] tones_c;
	logic       tone_end;

	// a 0 bit flips the tone, a 1 bit holds it
	always_comb begin
		tone_end = tone_q;
		tones_c  = '0;
		for (int i = 0; i < 8; i++) begin
			if (!emit.data[i]) tone_end = ~tone_end;
			tones_c[i] = tone_end;
		end
	end

	assign adv = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (emit.restart) begin
				tone_q <= 1'b0;
			end else if (emit.emit) begin
				tone_q <= tone_end;
			end
			if (adv) valid_q <= emit.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit.emit) begin
			byte_q  <= emit.data;
			tones_q <= tones_c;
			last_q  <= emit.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {tones_q, byte_q};
	assign m_tlast  = last_q;

	`AX25_ASSERT_NXT(a_tone_hold, valid_q && !m_tready && !emit.restart, $stable(tone_q), "tone moved while output stalled")

endmodule

/* rtl/core/ax25afsk_seq.sv */
`include "ax25_frame_afsk_tone_encoder_macros.svh"

module ax25afsk_seq #(
	parameter int unsigned CALLSIGN_BYTES = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic [47:0]          callsign,
	input  logic [7:0]           ssid,
	input  logic [5:0]           preamble_count,
	input  logic [5:0]           tail_count,
	input  logic [15:0]          crc,
	input  logic                 adv,
	output ax25afsk_pkg::emit_t  emit
);
	import ax25afsk_pkg::*;

	localparam logic [CNT_W-1:0] CB = CNT_W'(CALLSIGN_BYTES);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       data_q, data_d;
	logic [7:0]       byte_c;
	logic             last_c;
	logic             fire;
	logic             accept;
	logic [CNT_W-1:0] pre_n;
	logic [CNT_W-1:0] tail_n;
	logic [47:0]      call_sh;

	assign pre_n   = sat_count(preamble_count);
	assign tail_n  = sat_count(tail_count);
	// bytes beyond the register shift out as zero
	assign call_sh = callsign >> {cnt_q[2:0], 3'b000};

	assign fire     = (phase_q != PH_IDLE) && adv;
	assign s_tready = (phase_q == PH_IDLE) || (fire && last_c);
	assign accept   = s_tvalid && s_tready;

	// byte and last flag for the current phase
	always_comb begin
		byte_c = 8'd0;
		last_c = 1'b0;
		case (phase_q)
			PH_PRE:   byte_c = FLAG_BYTE;
			PH_ADDR1,
			PH_ADDR2: byte_c = (cnt_q < CB) ? call_sh[7:0] : ssid;
			PH_CTRL:  byte_c = CTRL_BYTE;
			PH_PID: begin
				byte_c = PID_BYTE;
				last_c = 1'b1;
			end
			PH_DATA: begin
				byte_c = data_q;
				last_c = 1'b1;
			end
			PH_CRCLO: byte_c = crc[7:0];
			PH_CRCHI: begin
				byte_c = crc[15:8];
				last_c = (tail_n == '0);
			end
			PH_TAIL: begin
				byte_c = FLAG_BYTE;
				last_c = (cnt_q == '0);
			end
			default: begin
				byte_c = 8'd0;
				last_c = 1'b0;
			end
		endcase
	end

	always_comb begin
		emit.emit    = fire;
		emit.data    = byte_c;
		emit.last    = last_c;
		emit.fold    = (phase_q == PH_DATA);
		emit.restart = accept && (s_tuser == CMD_START);
	end

	// next phase: advance on a sent byte, then load a new command
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		data_d  = data_q;
		if (fire) begin
			case (phase_q)
				PH_PRE: begin
					if (cnt_q == '0) begin
						phase_d = PH_ADDR1;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
				PH_ADDR1: begin
					if (cnt_q == CB) begin
						phase_d = PH_ADDR2;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
				PH_ADDR2: begin
					if (cnt_q == CB) begin
						phase_d = PH_CTRL;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
				PH_CTRL:  phase_d = PH_PID;
				PH_PID:   phase_d = PH_IDLE;
				PH_DATA:  phase_d = PH_IDLE;
				PH_CRCLO: phase_d = PH_CRCHI;
				PH_CRCHI: begin
					if (tail_n == '0) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_TAIL;
						cnt_d   = tail_n - 1'b1;
					end
				end
				PH_TAIL: begin
					if (cnt_q == '0) begin
						phase_d = PH_IDLE;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		if (accept) begin
			case (s_tuser)
				CMD_START: begin
					if (pre_n == '0) begin
						phase_d = PH_ADDR1;
						cnt_d   = '0;
					end else begin
						phase_d = PH_PRE;
						cnt_d   = pre_n - 1'b1;
					end
				end
				CMD_PAYLOAD: begin
					phase_d = PH_DATA;
					data_d  = s_tdata;
				end
				CMD_END: phase_d = PH_CRCLO;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	`AX25_ASSERT_IMP(a_last_frees_input, fire && last_c, s_tready, "input held after final byte")
	`AX25_ASSERT_NXT(a_stall_holds, (phase_q != PH_IDLE) && !adv && !s_tvalid, $stable(phase_q) && $stable(cnt_q), "sequencer moved during stall")
	`AX25_ASSERT_IMP(a_flag_count, (phase_q == PH_PRE) || (phase_q == PH_TAIL), cnt_q < COUNT_MAX, "flag counter out of range")
	`AX25_ASSERT_IMP(a_addr_count, (phase_q == PH_ADDR1) || (phase_q == PH_ADDR2), cnt_q <= CB, "address counter out of range")

endmodule

/* rtl/core/ax25_frame_afsk_tone_encoder.sv */
// Frame builder with NRZI AFSK tone coding. Each input beat is a command
// (tuser): start emits the preamble flags, the callsign and SSID twice, 0x03
// and 0xF0 and resets the tone to 0 and the CRC to 0xFFFF; payload emits
// tdata and folds it into the CRC-16 (0x1021, not reflected); end emits the
// CRC low then high byte and the tail flags; command 3 is dropped. Every frame
// byte leaves as one output beat carrying the byte and its eight tone bits,
// tlast marking the final byte of a command. The output register sends one
// byte per cycle while m_tready is high. A command emits one byte for payload,
// preamble_count + 2*(CALLSIGN_BYTES+1) + 2 for start and tail_count + 2 for
// end (counts limited to 32). The next command is taken in the cycle its
// predecessor's last byte moves to the output register, so payload beats flow
// back to back. Users must write configuration (callsign at 0x00, ssid at
// 0x08, preamble_count at 0x10, tail_count at 0x18) while idle; not enforced.
module ax25_frame_afsk_tone_encoder #(
	parameter int unsigned CALLSIGN_BYTES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte [7:0]
	input  logic [1:0]  s_tuser,   // cmd [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // sent_byte [7:0], tones [15:8]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import ax25afsk_pkg::*;

	logic [47:0] callsign_q;
	logic [7:0]  ssid_q;
	logic [5:0]  preamble_q;
	logic [5:0]  tail_q;
	logic        wr;
	reg_idx_t    idx;
	logic [15:0] crc;
	logic        adv;
	emit_t       emit;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:3]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			callsign_q <= '0;
			ssid_q     <= '0;
			preamble_q <= PREAMBLE_RESET;
			tail_q     <= TAIL_RESET;
		end else if (wr) begin
			case (idx)
				REG_CALLSIGN: callsign_q <= pwdata[47:0];
				REG_SSID:     ssid_q     <= pwdata[7:0];
				REG_PREAMBLE: preamble_q <= pwdata[5:0];
				REG_TAIL:     tail_q     <= pwdata[5:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CALLSIGN: prdata = {16'd0, callsign_q};
			REG_SSID:     prdata = {56'd0, ssid_q};
			REG_PREAMBLE: prdata = {58'd0, preamble_q};
			REG_TAIL:     prdata = {58'd0, tail_q};
			default:      prdata = '0;
		endcase
	end

	ax25afsk_seq #(
		.CALLSIGN_BYTES(CALLSIGN_BYTES)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.callsign      (callsign_q),
		.ssid          (ssid_q),
		.preamble_count(preamble_q),
		.tail_count    (tail_q),
		.crc           (crc),
		.adv           (adv),
		.emit          (emit)
	);

	ax25afsk_crc u_crc (
		.clk   (clk),
		.arst_n(arst_n),
		.emit  (emit),
		.crc   (crc)
	);

	ax25afsk_nrzi u_nrzi (
		.clk     (clk),
		.arst_n  (arst_n),
		.emit    (emit),
		.adv     (adv),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

/* test/tb_ax25_frame_afsk_tone_encoder.sv */
`timescale 1ns / 1ps

import ax25afsk_pkg::*;

typedef struct packed {
	logic [7:0] sent;
	logic [7:0] tones;
	logic       last;
} tone_beat_t;

class tone_frame_scoreboard;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	int          callsign_len;
	logic [47:0] callsign;
	logic [7:0]  ssid;
	logic [5:0]  preamble_count;
	logic [5:0]  tail_count;
	logic        tone_high;
	logic [15:0] crc;
	tone_beat_t  pending[$];
	int unsigned mismatches;

	function new(int len);
		callsign_len = len;
		callsign = '0;
		ssid = '0;
		preamble_count = PREAMBLE_RESET;
		tail_count = TAIL_RESET;
		tone_high = 1'b0;
		crc = CRC_INIT;
		mismatches = 0;
	endfunction

	function void write_register(reg_idx_t idx, logic [63:0] value);
		case (idx)
			REG_CALLSIGN: callsign = value[47:0];
			REG_SSID:     ssid = value[7:0];
			REG_PREAMBLE: preamble_count = value[5:0];
			REG_TAIL:     tail_count = value[5:0];
			default: ;
		endcase
	endfunction

	function logic [5:0] clamp_count(logic [5:0] v);
		return (v > COUNT_MAX) ? COUNT_MAX : v;
	endfunction

	// nrzi: a zero bit flips the tone, a one keeps it
	function void push_byte(logic [7:0] b, logic is_last);
		tone_beat_t beat;
		beat.sent = b;
		beat.last = is_last;
		beat.tones = '0;
		for (int i = 0; i < 8; i++) begin
			if (!b[i])
				tone_high = ~tone_high;
			beat.tones[i] = tone_high;
		end
		pending.push_back(beat);
	endfunction

	function void fold_crc(logic [7:0] b);
		crc ^= {b, 8'h00};
		for (int i = 0; i < 8; i++)
			crc = crc[15] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
	endfunction

	function void push_address();
		logic [7:0] ch;
		for (int i = 0; i < callsign_len; i++) begin
			// bytes past the 48-bit register go out as zero
			ch = 8'(callsign >> (8 * i));
			push_byte(ch, 1'b0);
		end
		push_byte(ssid, 1'b0);
	endfunction

	function void note_command(cmd_t cmd, logic [7:0] data);
		int n;
		case (cmd)
			CMD_START: begin
				tone_high = 1'b0;
				crc = CRC_INIT;
				n = int'(clamp_count(preamble_count));
				repeat (n) push_byte(FLAG_BYTE, 1'b0);
				push_address();
				push_address();
				push_byte(CTRL_BYTE, 1'b0);
				push_byte(PID_BYTE, 1'b1);
			end
			CMD_PAYLOAD: begin
				push_byte(data, 1'b1);
				fold_crc(data);
			end
			CMD_END: begin
				n = int'(clamp_count(tail_count));
				push_byte(crc[7:0], 1'b0);
				push_byte(crc[15:8], n == 0);
				for (int i = 0; i < n; i++)
					push_byte(FLAG_BYTE, i == n - 1);
			end
			default: ;
		endcase
	endfunction

	task report(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task check_beat(logic [7:0] sent, logic [7:0] tones, logic last);
		tone_beat_t exp_beat;
		if (pending.size() == 0) begin
			report($sformatf("unexpected beat byte=%02h tones=%02h last=%0b",
				sent, tones, last));
		end else begin
			exp_beat = pending.pop_front();
			if (sent !== exp_beat.sent)
				report($sformatf("sent_byte %02h, want %02h", sent, exp_beat.sent));
			if (tones !== exp_beat.tones)
				report($sformatf("tones %02h, want %02h (byte %02h)",
					tones, exp_beat.tones, exp_beat.sent));
			if (last !== exp_beat.last)
				report($sformatf("tlast %0b, want %0b (byte %02h)",
					last, exp_beat.last, exp_beat.sent));
		end
	endtask
endclass

module tb_ax25_frame_afsk_tone_encoder;
	localparam int CALLSIGN_BYTES = 6;
	localparam int RANDOM_ITEMS = 500;
	localparam int RANDOM_PHASES = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT = 10_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // data_byte [7:0]
	logic [1:0]  s_tuser;   // cmd [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // sent_byte [7:0], tones [15:8]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	tone_frame_scoreboard sb = new(CALLSIGN_BYTES);

	int unsigned cycle_count = 0;
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;

	ax25_frame_afsk_tone_encoder #(
		.CALLSIGN_BYTES(CALLSIGN_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	// output side: random backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct)
				stall_left = pick_gap();
			if (stall_left != 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
			end
			@(posedge clk);
			if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready)
				sb.check_beat(m_tdata[7:0], m_tdata[15:8], m_tlast);
		end
	end

	task send_command(cmd_t cmd, logic [7:0] data);
		int gap;
		gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = data;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_command(cmd, data);
	endtask

	// sender stops until every expected beat is out
	task drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task apb_write(reg_idx_t idx, logic [63:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_register(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic [5:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 6'd0;
		else if (r == 2)
			return 6'($urandom_range(32, 63));
		else
			return 6'($urandom_range(1, 6));
	endfunction

	task program_random_settings();
		logic [63:0] value;
		value = {$urandom, $urandom};
		if ($urandom_range(0, 5) == 0)
			value[47:0] = $urandom_range(0, 1) ? '1 : '0;
		apb_write(REG_CALLSIGN, value);
		value = {$urandom, $urandom};
		apb_write(REG_SSID, value);
		value = {$urandom, $urandom};
		value[5:0] = pick_count();
		apb_write(REG_PREAMBLE, value);
		value = {$urandom, $urandom};
		value[5:0] = pick_count();
		apb_write(REG_TAIL, value);
	endtask

	initial begin
		int n;
		int counted;
		cmd_t cmd;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_NONE;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings; commands out of order, ignored command, repeated end
		send_command(CMD_PAYLOAD, 8'hA5);
		send_command(CMD_END, 8'h00);
		send_command(CMD_NONE, 8'hFF);
		send_command(CMD_START, 8'h00);
		send_command(CMD_PAYLOAD, 8'h00);
		send_command(CMD_PAYLOAD, 8'hFF);
		send_command(CMD_END, 8'hFF);
		send_command(CMD_END, 8'h00);

		// all-ones address, no flags at either end
		drain_results();
		apb_write(REG_CALLSIGN, '1);
		apb_write(REG_SSID, '1);
		apb_write(REG_PREAMBLE, 64'd0);
		apb_write(REG_TAIL, 64'd0);
		send_command(CMD_START, 8'hFF);
		send_command(CMD_PAYLOAD, 8'h80);
		send_command(CMD_NONE, 8'h00);
		send_command(CMD_PAYLOAD, 8'h01);
		send_command(CMD_END, 8'h55);

		// counts above range clamp to the maximum
		drain_results();
		apb_write(REG_CALLSIGN, 64'd0);
		apb_write(REG_SSID, 64'd0);
		apb_write(REG_PREAMBLE, 64'd63);
		apb_write(REG_TAIL, 64'd33);
		send_command(CMD_START, 8'h00);
		send_command(CMD_PAYLOAD, FLAG_BYTE);
		send_command(CMD_END, 8'h00);

		drain_results();
		apb_write(REG_CALLSIGN, {$urandom, $urandom});
		apb_write(REG_PREAMBLE, 64'(COUNT_MAX));
		apb_write(REG_TAIL, 64'(COUNT_MAX));
		send_command(CMD_START, 8'h3C);
		send_command(CMD_END, 8'hC3);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			program_random_settings();
			tx_gap_pct = (phase % 4 == 0) ? 0 : $urandom_range(10, 50);
			rx_stall_pct = (phase % 4 < 2) ? 0 : $urandom_range(10, 50);
			counted = 0;
			while (counted < RANDOM_ITEMS / RANDOM_PHASES) begin
				if ($urandom_range(0, 19) == 0)
					drain_results();
				if ($urandom_range(0, 99) < 85) begin
					send_command(CMD_START, 8'($urandom_range(0, 255)));
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
						: $urandom_range(0, 12);
					repeat (n)
						send_command(CMD_PAYLOAD, 8'($urandom_range(0, 255)));
					send_command(CMD_END, 8'($urandom_range(0, 255)));
					counted += n + 2;
					if ($urandom_range(0, 9) == 0) begin
						send_command(CMD_END, 8'($urandom_range(0, 255)));
						counted++;
					end
				end else begin
					cmd = cmd_t'($urandom_range(0, 3));
					send_command(cmd, 8'($urandom_range(0, 255)));
					if (cmd != CMD_NONE)
						counted++;
				end
			end
		end

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ax25afsk_pkg.sv
rtl/core/ax25afsk_crc.sv
rtl/core/ax25afsk_nrzi.sv
rtl/core/ax25afsk_seq.sv
rtl/core/ax25_frame_afsk_tone_encoder.sv
test/tb_ax25_frame_afsk_tone_encoder.sv
